// ----- hw/rtl/lgce_pkg.sv -----
// ----------------------------------------------------------------------------
// lgce_pkg
// Types, constants and helper functions for the location grid code encoder.
// ----------------------------------------------------------------------------
package lgce_pkg;

  localparam int unsigned LAT_IN_W = 34;
  localparam int unsigned LNG_IN_W = 33;
  localparam int unsigned LAT_W    = 33;
  localparam int unsigned LNG_W    = 32;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned DIG_W    = 5;
  localparam int unsigned GRID_W   = 3;
  localparam int unsigned NPAIR    = 5;
  localparam int unsigned NBUF     = 16;

  localparam logic signed [LAT_IN_W-1:0] LAT_HALF = 34'sd2250000000;
  localparam logic [LAT_W-1:0]           LAT_FULL = 33'd4500000000;
  localparam logic [34:0]                LNG_HALF = 35'd1474560000;
  localparam logic [34:0]                LNG_FULL = 35'd2949120000;

  // Place values of the pair digits, least significant first.
  localparam logic [LAT_W-1:0] LAT_DIV [NPAIR] = '{
    33'd3125, 33'd62500, 33'd1250000, 33'd25000000, 33'd500000000
  };
  localparam logic [LAT_W-1:0] LNG_DIV [NPAIR] = '{
    33'd1024, 33'd20480, 33'd409600, 33'd8192000, 33'd163840000
  };

  localparam logic [CHAR_W-1:0] CHAR_PLUS = 7'h2B;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;

  typedef struct packed {
    logic [DIG_W-1:0] digit;
    logic [LAT_W-1:0] rem;
  } digit_t;

  typedef struct packed {
    logic [LAT_W-1:0]                   lat;
    logic [LNG_W-1:0]                   lng;
    logic [LEN_W-1:0]                   len;
    logic [NPAIR-1:0][DIG_W-1:0]        lat_dig;
    logic [NPAIR-1:0][DIG_W-1:0]        lng_dig;
    logic [NPAIR-1:0][GRID_W-1:0]       lat_grid;
  } pipe_t;

  // One digit below 20 of x by place value c: parallel compares, then select.
  function automatic digit_t div_digit(input logic [LAT_W-1:0] x,
                                       input logic [LAT_W-1:0] c);
    digit_t      r;
    logic [34:0] diff;
    r.digit = '0;
    r.rem   = x;
    for (int k = 1; k < 20; k++) begin
      diff = {2'b00, x} - (35'(c) * 35'(k));
      if (!diff[34]) begin
        r.digit = DIG_W'(k);
        r.rem   = diff[LAT_W-1:0];
      end
    end
    return r;
  endfunction

  // Half cell height, rounded up, for the pole adjustment.
  function automatic logic [27:0] pole_offset(input logic [LEN_W-1:0] len);
    logic [27:0] r;
    unique case (len)
      4'd2:    r = 28'd250000000;
      4'd4:    r = 28'd12500000;
      4'd6:    r = 28'd625000;
      4'd8:    r = 28'd31250;
      4'd10:   r = 28'd1563;
      4'd11:   r = 28'd313;
      4'd12:   r = 28'd63;
      4'd13:   r = 28'd13;
      4'd14:   r = 28'd3;
      default: r = 28'd1;
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] r;
    unique case (d)
      5'd0:    r = 7'h32;
      5'd1:    r = 7'h33;
      5'd2:    r = 7'h34;
      5'd3:    r = 7'h35;
      5'd4:    r = 7'h36;
      5'd5:    r = 7'h37;
      5'd6:    r = 7'h38;
      5'd7:    r = 7'h39;
      5'd8:    r = 7'h43;
      5'd9:    r = 7'h46;
      5'd10:   r = 7'h47;
      5'd11:   r = 7'h48;
      5'd12:   r = 7'h4A;
      5'd13:   r = 7'h4D;
      5'd14:   r = 7'h50;
      5'd15:   r = 7'h51;
      5'd16:   r = 7'h52;
      5'd17:   r = 7'h56;
      5'd18:   r = 7'h57;
      5'd19:   r = 7'h58;
      default: r = CHAR_ZERO;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/location_grid_code_encoder.sv -----
// ----------------------------------------------------------------------------
// location_grid_code_encoder
// Encodes a fixed-point latitude/longitude pair into a grid location code,
// one ASCII character per output transfer.
//
// Input channel: in_valid_i/in_stall_o with latitude_i (1/25e6 degree) and
// longitude_i (1/8.192e6 degree). Output channel: out_valid_o/out_stall_i
// with character_o, position_o and last_o; last_o marks the final character.
// cfg_wen_i/cfg_wdata_i write code_length (reset 15); write only when idle.
// Each code passes through stage registers 0..7, stage 0 loading at the
// input transfer, and then the character shift register. Each code is
// max(len+1, 9) characters, len being the effective length; the character
// shift register sends one character per cycle while out_stall_i is low.
// The 8-stage digit pipeline takes an input every cycle while it has room; a
// new code is loaded at the edge on which the previous last character moves.
// Reset empties the pipeline and the output. A stall on the output holds the
// current character; the pipeline then fills and stalls the input.
// ----------------------------------------------------------------------------
module location_grid_code_encoder
  import lgce_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 15
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wen_i,
  input  logic [LEN_W-1:0]           cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [LAT_IN_W-1:0] latitude_i,
  input  logic signed [LNG_IN_W-1:0] longitude_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [CHAR_W-1:0]          character_o,
  output logic [POS_W-1:0]           position_o,
  output logic                       last_o
);

  localparam int unsigned NCHAR = MAX_DIGITS + 1;
  localparam int unsigned NS    = 8;

  logic [LEN_W-1:0] code_length_q;
  logic [LEN_W-1:0] len_eff;

  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;
  pipe_t         pipe_q [NS];
  pipe_t         pipe_d [NS];

  logic                          ser_vld_q;
  logic [NCHAR-1:0][CHAR_W-1:0]  ser_chars_q;
  logic [POS_W-1:0]              ser_pos_q;
  logic [POS_W-1:0]              ser_cnt_m1_q;
  logic                          ser_last;
  logic                          ser_ready;
  logic [NBUF-1:0][CHAR_W-1:0]   buf_d;
  logic [POS_W-1:0]              cnt_m1_d;

  logic [34:0]      lat_sum;
  logic [LAT_W-1:0] lat_val;
  logic [34:0]      lng_t;
  logic [34:0]      lng_adj;

  // Config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_length_q <= LEN_W'(15);
    end else if (cfg_wen_i) begin
      code_length_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    len_eff = code_length_q;
    if (code_length_q > LEN_W'(MAX_DIGITS)) len_eff = LEN_W'(MAX_DIGITS);
    if (len_eff < LEN_W'(2)) len_eff = LEN_W'(2);
    if (len_eff < LEN_W'(10) && len_eff[0]) len_eff = len_eff + LEN_W'(1);
  end

  // Stage 0: clamp, pole adjust, wrap
  always_comb begin
    lat_sum = {latitude_i[LAT_IN_W-1], latitude_i} + 35'(LAT_HALF);
    if (latitude_i >= LAT_HALF) begin
      lat_val = LAT_FULL - LAT_W'(pole_offset(len_eff));
    end else if (latitude_i <= -LAT_HALF) begin
      lat_val = '0;
    end else begin
      lat_val = lat_sum[LAT_W-1:0];
    end
    lng_t = {{2{longitude_i[LNG_IN_W-1]}}, longitude_i} + LNG_HALF;
    if (lng_t[34]) begin
      lng_adj = lng_t + LNG_FULL;
    end else if (lng_t >= LNG_FULL) begin
      lng_adj = lng_t - LNG_FULL;
    end else begin
      lng_adj = lng_t;
    end
  end

  // Stage datapath
  always_comb begin
    digit_t rl, rg, ra, rb;
    pipe_d[0]     = '0;
    pipe_d[0].lat = lat_val;
    pipe_d[0].lng = lng_adj[LNG_W-1:0];
    pipe_d[0].len = len_eff;
    // stages 1..5: pair digits, most significant first
    for (int k = 1; k <= NPAIR; k++) begin
      rl = div_digit(pipe_q[k-1].lat, LAT_DIV[NPAIR-k]);
      rg = div_digit({1'b0, pipe_q[k-1].lng}, LNG_DIV[NPAIR-k]);
      pipe_d[k] = pipe_q[k-1];
      pipe_d[k].lat_dig[NPAIR-k] = rl.digit;
      pipe_d[k].lng_dig[NPAIR-k] = rg.digit;
      pipe_d[k].lat = rl.rem;
      pipe_d[k].lng = rg.rem[LNG_W-1:0];
    end
    // stage 6: base-5 grid rows 4 and 3
    ra = div_digit(pipe_q[5].lat, 33'd625);
    rb = div_digit(ra.rem, 33'd125);
    pipe_d[6] = pipe_q[5];
    pipe_d[6].lat_grid[4] = ra.digit[GRID_W-1:0];
    pipe_d[6].lat_grid[3] = rb.digit[GRID_W-1:0];
    pipe_d[6].lat = rb.rem;
    // stage 7: grid rows 2, 1, 0
    ra = div_digit(pipe_q[6].lat, 33'd25);
    rb = div_digit(ra.rem, 33'd5);
    pipe_d[7] = pipe_q[6];
    pipe_d[7].lat_grid[2] = ra.digit[GRID_W-1:0];
    pipe_d[7].lat_grid[1] = rb.digit[GRID_W-1:0];
    pipe_d[7].lat_grid[0] = rb.rem[GRID_W-1:0];
    pipe_d[7].lat = rb.rem;
  end

  // Pipeline handshake
  always_comb begin
    rdy[NS] = ser_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) pipe_q[k] <= pipe_d[k];
    end
  end

  // Character assembly
  always_comb begin
    pipe_t p;
    p = pipe_q[NS-1];
    for (int j = 1; j < NPAIR; j++) begin
      buf_d[2*(NPAIR-1-j)]     = alpha_char(p.lat_dig[j]);
      buf_d[2*(NPAIR-1-j) + 1] = alpha_char(p.lng_dig[j]);
    end
    buf_d[8]  = CHAR_PLUS;
    buf_d[9]  = alpha_char(p.lat_dig[0]);
    buf_d[10] = alpha_char(p.lng_dig[0]);
    for (int m = 0; m < NPAIR; m++) begin
      buf_d[11+m] = alpha_char({p.lat_grid[NPAIR-1-m], p.lng[9-2*m -: 2]});
    end
    for (int i = 0; i < 8; i++) begin
      if (LEN_W'(i) >= p.len) buf_d[i] = CHAR_ZERO;
    end
    cnt_m1_d = (p.len < LEN_W'(8)) ? POS_W'(8) : p.len;
  end

  // Output shift register
  assign ser_last  = (ser_pos_q == ser_cnt_m1_q);
  assign ser_ready = !ser_vld_q || (!out_stall_i && ser_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      ser_pos_q <= '0;
    end else if (ser_ready) begin
      ser_vld_q <= vld_q[NS-1];
      ser_pos_q <= '0;
    end else if (!out_stall_i) begin
      ser_pos_q <= ser_pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_ready) begin
      ser_chars_q  <= buf_d[NCHAR-1:0];
      ser_cnt_m1_q <= cnt_m1_d;
    end else if (!out_stall_i) begin
      ser_chars_q <= {CHAR_ZERO, ser_chars_q[NCHAR-1:1]};
    end
  end

  assign out_valid_o = ser_vld_q;
  assign character_o = ser_chars_q[0];
  assign position_o  = ser_pos_q;
  assign last_o      = ser_last;

endmodule

// ----- verif/location_grid_code_encoder_test.sv -----
// ----------------------------------------------------------------------------
// location_grid_code_encoder_test
// Self-checking bench for the grid code encoder. A table of directed
// coordinate pairs (poles, clamping, longitude wrap, all code lengths but 4)
// runs first, then about 200 random pairs over several code lengths. Each
// output character is compared with the row's text or a local model of the
// encoding. The sender works in bursts and the receiver stalls on its own
// pattern, with long hold-offs that back the pipeline up into the input.
// ----------------------------------------------------------------------------
module location_grid_code_encoder_test;
  import lgce_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned ITEMS_PER_PHASE = 20;
  localparam logic [159:0] ALPHABET = "23456789CFGHJMPQRVWX";

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic              last;
  } code_char_t;

  typedef struct packed {
    logic [LEN_W-1:0]           len;
    logic signed [LAT_IN_W-1:0] lat;
    logic signed [LNG_IN_W-1:0] lng;
    logic [127:0]               text;
  } coord_row_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_wen_i   = 1'b0;
  logic [LEN_W-1:0]           cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [LAT_IN_W-1:0] latitude_i  = '0;
  logic signed [LNG_IN_W-1:0] longitude_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [CHAR_W-1:0]          character_o;
  logic [POS_W-1:0]           position_o;
  logic                       last_o;

  code_char_t       code_chars_q [$];
  coord_row_t       coord_rows [$];
  logic [LEN_W-1:0] code_len = 4'd15;
  int               burst_left = 0;
  int               pairs_sent = 0;
  int               chars_seen = 0;
  int               codes_seen = 0;
  int               len_writes = 0;
  int               mismatches = 0;
  int               hold_request = 0;
  logic             hold_active = 1'b0;
  int unsigned      rx_cycle = 0;

  location_grid_code_encoder #(.MAX_DIGITS(15)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wen_i   (cfg_wen_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .latitude_i  (latitude_i),
    .longitude_i (longitude_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .position_o  (position_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [CHAR_W-1:0] alphabet_at(input longint unsigned k);
    return ALPHABET[8*(19-k) +: 7];
  endfunction

  // Expected characters of one code at the current length.
  function automatic void predict_code(input logic signed [LAT_IN_W-1:0] lat_in,
                                       input logic signed [LNG_IN_W-1:0] lng_in);
    int unsigned       eff;
    int unsigned       count;
    int unsigned       li;
    longint            lat_s;
    longint            lng_s;
    longint unsigned   lat_v;
    longint unsigned   lng_v;
    longint unsigned   cell_h;
    logic [CHAR_W-1:0] code [16];
    eff = code_len;
    if (eff > 15) eff = 15;
    if (eff < 2) eff = 2;
    if (eff < 10 && eff[0]) eff++;
    lat_s = lat_in;
    if (lat_s > 64'sd2250000000) lat_s = 64'sd2250000000;
    if (lat_s < -64'sd2250000000) lat_s = -64'sd2250000000;
    lat_v = lat_s + 64'sd2250000000;
    if (lat_v >= 64'd4500000000) begin
      cell_h = 3125;
      if (eff <= 10) begin
        for (int p = eff; p < 10; p += 2) cell_h *= 20;
      end else begin
        for (int p = 10; p < eff; p++) cell_h /= 5;
      end
      lat_v -= (cell_h + 1) / 2;
    end
    lng_s = lng_in;
    lng_s = (lng_s + 64'sd1474560000) % 64'sd2949120000;
    if (lng_s < 0) lng_s += 64'sd2949120000;
    lng_v = lng_s;
    for (int p = 0; p < 16; p++) code[p] = CHAR_ZERO;
    if (eff > 10) begin
      for (int g = 0; g < 5; g++) begin
        code[15-g] = alphabet_at((lat_v % 5) * 4 + (lng_v % 4));
        lat_v /= 5;
        lng_v /= 4;
      end
    end else begin
      lat_v /= 3125;
      lng_v /= 1024;
    end
    for (int d = 0; d < 5; d++) begin
      li = (d == 0) ? 9 : 8 - 2 * d;
      code[li]   = alphabet_at(lat_v % 20);
      code[li+1] = alphabet_at(lng_v % 20);
      lat_v /= 20;
      lng_v /= 20;
    end
    code[8] = CHAR_PLUS;
    if (eff < 8) begin
      for (int p = eff; p < 8; p++) code[p] = CHAR_ZERO;
    end
    count = (eff + 1 < 9) ? 9 : eff + 1;
    for (int p = 0; p < count; p++) begin
      code_chars_q.push_back('{ch: code[p], pos: POS_W'(p), last: (p == count - 1)});
    end
  endfunction

  function automatic void push_text(input logic [127:0] text);
    logic [CHAR_W-1:0] chars [$];
    for (int b = 15; b >= 0; b--) begin
      if (text[8*b +: 8] != 8'h00) chars.push_back(text[8*b +: 7]);
    end
    foreach (chars[p]) begin
      code_chars_q.push_back('{ch: chars[p], pos: POS_W'(p), last: (p == chars.size() - 1)});
    end
  endfunction

  function automatic void add_row(input logic [LEN_W-1:0] len, input longint lat,
                                  input longint lng, input logic [127:0] text);
    coord_rows.push_back('{len: len, lat: lat[LAT_IN_W-1:0], lng: lng[LNG_IN_W-1:0],
                           text: text});
  endfunction

  function automatic longint pick_between(input longint lo, input longint hi);
    longint unsigned r;
    r = {$urandom, $urandom};
    return lo + longint'(r % longint'(hi - lo + 1));
  endfunction

  task automatic send_pair(input logic signed [LAT_IN_W-1:0] lat,
                           input logic signed [LNG_IN_W-1:0] lng,
                           input logic [127:0] text);
    latitude_i  <= lat;
    longitude_i <= lng;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (text != '0) push_text(text);
    else predict_code(lat, lng);
    pairs_sent++;
  endtask

  task automatic offer_pair(input logic signed [LAT_IN_W-1:0] lat,
                            input logic signed [LNG_IN_W-1:0] lng,
                            input logic [127:0] text);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    send_pair(lat, lng, text);
  endtask

  // Length is changed only with the pipeline empty.
  task automatic set_code_length(input logic [LEN_W-1:0] len);
    in_valid_i <= 1'b0;
    while (code_chars_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    cfg_wen_i   <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_wen_i <= 1'b0;
    code_len   = len;
    burst_left = 0;
    len_writes++;
  endtask

  task automatic random_pair();
    longint lat;
    longint lng;
    case ($urandom_range(0, 9))
      0:       lat = 64'sd2250000000;
      1:       lat = -64'sd2250000000;
      2:       lat = pick_between(64'sd2250000001, 64'sd4500000000);
      3:       lat = pick_between(-64'sd4500000000, -64'sd2250000001);
      4:       lat = pick_between(64'sd2249998000, 64'sd2250000000);
      default: lat = pick_between(-64'sd2250000000, 64'sd2250000000);
    endcase
    case ($urandom_range(0, 9))
      0:       lng = -64'sd2949120000;
      1:       lng = 64'sd2949119999;
      2:       lng = 64'sd1474560000;
      3:       lng = -64'sd1474560000;
      default: lng = pick_between(-64'sd2949120000, 64'sd2949119999);
    endcase
    offer_pair(lat[LAT_IN_W-1:0], lng[LNG_IN_W-1:0], '0);
  endtask

  // Receiver: checks each transfer and stalls on a pattern that rotates through four modes.
  always @(posedge clk_i) begin : rx_side
    code_char_t want;
    logic       stall;
    rx_cycle++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_seen++;
      if (last_o) codes_seen++;
      if (code_chars_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected char 0x%02h pos %0d last %0b", character_o, position_o, last_o);
      end else begin
        want = code_chars_q.pop_front();
        if (want.ch !== character_o || want.pos !== position_o || want.last !== last_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp char 0x%02h pos %0d last %0b, got 0x%02h pos %0d last %0b",
                     want.ch, want.pos, want.last, character_o, position_o, last_o);
        end
      end
    end
    case ((rx_cycle / 64) % 4)
      0:       stall = 1'b0;
      1:       stall = ($urandom_range(0, 3) == 0);
      2:       stall = ((rx_cycle % 8) < 3);
      default: stall = ($urandom_range(0, 9) < 6);
    endcase
    out_stall_i <= hold_active || stall;
  end

  initial begin : hold_off
    wait (hold_request >= 1);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active <= 1'b0;
    wait (hold_request >= 2);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout");
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int               directed;
    logic [LEN_W-1:0] phase_lens [9];
    logic [LEN_W-1:0] len;
    phase_lens = '{4'd15, 4'd0, 4'd2, 4'd10, 4'd11, 4'd4, 4'd8, 4'd1, 4'd14};

    add_row(15, 0, 0, "6FG22222+2222222");
    add_row(15, 64'sd4500000000, 64'sd2949119999, '0);
    add_row(15, -64'sd4500000000, -64'sd2949120000, '0);
    add_row(15, 64'sd2250000000, -64'sd1474560000, '0);
    add_row(15, -64'sd2250000000, 64'sd1474559999, '0);
    add_row(15, 64'sd123456789, 64'sd1474560000, '0);
    add_row(10, 0, 0, "6FG22222+22");
    add_row(10, -64'sd2250000000, -64'sd1474560000, "22222222+22");
    add_row(10, 64'sd2250000000, -64'sd1474560000, "C2X2X2X2+X2");
    add_row(10, 64'sd2250000001, 64'sd2949119999, '0);
    add_row(2, 0, 0, "6F000000+");
    add_row(2, 64'sd2250000000, 64'sd1000, '0);
    add_row(0, 0, 0, "6F000000+");
    add_row(0, 64'sd2250000000, -64'sd1000, '0);
    add_row(1, -1, -1, '0);
    add_row(3, 64'sd987654321, -64'sd987654321, '0);
    add_row(5, 64'sd2250000000, -64'sd1, '0);
    add_row(6, 64'sd2250000000, 64'sd5, '0);
    add_row(7, -64'sd4499999999, 64'sd2949119999, '0);
    add_row(8, 64'sd2250000000, -64'sd2949120000, '0);
    add_row(9, 64'sd2250000000, 0, '0);
    add_row(11, 64'sd2250000000, 0, '0);
    add_row(12, 64'sd2250000000, 0, '0);
    add_row(13, 64'sd2250000000, 0, '0);
    add_row(14, 64'sd2250000000, 0, '0);
    add_row(15, 64'sd2250000000, 0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; the first rows run on the reset length.
    foreach (coord_rows[r]) begin
      if (coord_rows[r].len != code_len) set_code_length(coord_rows[r].len);
      offer_pair(coord_rows[r].lat, coord_rows[r].lng, coord_rows[r].text);
    end
    directed = pairs_sent;

    for (int ph = 0; ph < 10; ph++) begin
      len = (ph < 9) ? phase_lens[ph] : LEN_W'($urandom_range(0, 15));
      set_code_length(len);
      if (ph == 2 || ph == 6) hold_request++;
      repeat (ITEMS_PER_PHASE) random_pair();
    end
    in_valid_i <= 1'b0;

    while (code_chars_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("%0d coordinate pairs (%0d directed), %0d length writes, %0d codes and %0d chars",
             pairs_sent, directed, len_writes, codes_seen, chars_seen);
    $display("covered poles, clamping, longitude wrap, all lengths 0..15, backpressure");
    if (mismatches == 0 && code_chars_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
